[rtl/core/rks_pkg.sv]
package rks_pkg;

  // Substitution table, also used as the key schedule
  localparam logic [7:0] SBOX [0:255] = '{
    8'd102, 8'd2,   8'd176, 8'd55,  8'd42,  8'd22,  8'd250, 8'd196,
    8'd85,  8'd206, 8'd197, 8'd121, 8'd66,  8'd61,  8'd86,  8'd134,
    8'd211, 8'd178, 8'd243, 8'd161, 8'd23,  8'd244, 8'd49,  8'd48,
    8'd39,  8'd62,  8'd242, 8'd180, 8'd109, 8'd229, 8'd248, 8'd247,
    8'd182, 8'd64,  8'd145, 8'd150, 8'd114, 8'd100, 8'd174, 8'd117,
    8'd98,  8'd99,  8'd154, 8'd120, 8'd149, 8'd217, 8'd52,  8'd225,
    8'd70,  8'd190, 8'd94,  8'd132, 8'd27,  8'd90,  8'd124, 8'd222,
    8'd183, 8'd74,  8'd88,  8'd164, 8'd152, 8'd202, 8'd10,  8'd253,
    8'd53,  8'd194, 8'd224, 8'd158, 8'd103, 8'd82,  8'd6,   8'd240,
    8'd28,  8'd93,  8'd40,  8'd13,  8'd30,  8'd146, 8'd8,   8'd14,
    8'd34,  8'd32,  8'd168, 8'd131, 8'd219, 8'd162, 8'd157, 8'd56,
    8'd21,  8'd104, 8'd122, 8'd33,  8'd234, 8'd67,  8'd5,   8'd143,
    8'd175, 8'd12,  8'd16,  8'd58,  8'd148, 8'd17,  8'd133, 8'd187,
    8'd128, 8'd91,  8'd186, 8'd110, 8'd106, 8'd79,  8'd127, 8'd113,
    8'd24,  8'd201, 8'd129, 8'd170, 8'd76,  8'd3,   8'd118, 8'd216,
    8'd220, 8'd111, 8'd185, 8'd155, 8'd84,  8'd199, 8'd160, 8'd204,
    8'd1,   8'd38,  8'd51,  8'd147, 8'd144, 8'd75,  8'd105, 8'd214,
    8'd81,  8'd254, 8'd235, 8'd172, 8'd78,  8'd41,  8'd83,  8'd0,
    8'd46,  8'd59,  8'd230, 8'd173, 8'd4,   8'd195, 8'd212, 8'd25,
    8'd112, 8'd29,  8'd57,  8'd163, 8'd179, 8'd89,  8'd19,  8'd95,
    8'd92,  8'd97,  8'd228, 8'd71,  8'd7,   8'd123, 8'd237, 8'd26,
    8'd68,  8'd210, 8'd44,  8'd251, 8'd226, 8'd54,  8'd45,  8'd73,
    8'd184, 8'd171, 8'd159, 8'd137, 8'd236, 8'd188, 8'd140, 8'd65,
    8'd136, 8'd192, 8'd166, 8'd193, 8'd119, 8'd125, 8'd36,  8'd18,
    8'd107, 8'd50,  8'd37,  8'd246, 8'd9,   8'd96,  8'd141, 8'd208,
    8'd31,  8'd181, 8'd165, 8'd80,  8'd231, 8'd252, 8'd177, 8'd215,
    8'd135, 8'd156, 8'd169, 8'd151, 8'd200, 8'd203, 8'd77,  8'd255,
    8'd142, 8'd69,  8'd241, 8'd191, 8'd205, 8'd153, 8'd138, 8'd15,
    8'd198, 8'd63,  8'd167, 8'd227, 8'd207, 8'd115, 8'd245, 8'd218,
    8'd101, 8'd87,  8'd233, 8'd238, 8'd239, 8'd72,  8'd232, 8'd20,
    8'd126, 8'd223, 8'd189, 8'd139, 8'd130, 8'd249, 8'd60,  8'd11,
    8'd43,  8'd35,  8'd116, 8'd221, 8'd47,  8'd209, 8'd213, 8'd108
  };

  // Longest run a pair can carry
  localparam logic [7:0] RUN_MAX = 8'hFF;

  // Control from the sequencer to a round lane
  typedef struct packed {
    logic load;
    logic step;
    logic inv;
  } rks_lane_ctl_t;

endpackage

[rtl/core/rks_round.sv]
module rks_round
  import rks_pkg::*;
#(
  parameter int ROT_AMT = 1
) (
  input  logic          clk,
  input  rks_lane_ctl_t ctl,
  input  logic [7:0]    load_val,
  input  logic [7:0]    k1,
  input  logic [7:0]    k2,
  output logic [7:0]    val
);

  localparam int R = ROT_AMT % 8;

  logic [15:0] dbl;
  logic [7:0]  rotated;
  logic [7:0]  sbox_in;

  // One round: key mix, rotate, key mix plus optional invert, substitute
  assign dbl     = {2{val ^ k1}};
  assign rotated = dbl[15-R -: 8];
  assign sbox_in = rotated ^ k2 ^ {8{ctl.inv}};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val <= load_val;
    end else if (ctl.step) begin
      val <= SBOX[sbox_in];
    end
  end

endmodule

[rtl/core/rle_keyed_byte_scrambler_top.sv]
// Keyed run-length scrambler.
// A pair is loaded, run through KEY_LEN-3 rounds, then handed off once the output
// is free; a byte that closes and ends a run costs two pairs.
// Throughput is set by the single round unit per lane, one round per cycle.
// A byte that only extends a run is taken without loading a pair.
// Synchronous active-high reset: no run held, parity 1, output empty.
module rle_keyed_byte_scrambler_top
  import rks_pkg::*;
#(
  parameter int KEY_LEN = 16,
  parameter int ROT     = 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] coded_value,
  output logic [7:0] coded_count,
  output logic       last_pair
);

  localparam int ROUNDS = KEY_LEN - 3;
  localparam int RND_W  = $clog2(ROUNDS + 1);
  localparam int IDX_W  = 9;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t       state;
  logic [7:0]   held_byte;
  logic [7:0]   run_length;
  logic         run_open;
  logic         parity;
  logic         pending_end;
  logic         cur_last;
  logic         lane_par;
  logic [RND_W-1:0] rnd;
  logic [RND_W-1:0] rnd_next;
  logic [7:0]   vk1, vk2, ck1, ck2;

  logic         in_fire;
  logic         match;
  logic         emit_prev;
  logic         out_free;
  logic         out_load;
  logic         lane_load;
  logic [7:0]   ld_val;
  logic [7:0]   ld_cnt;
  logic         ld_par;
  logic [7:0]   val_q, cnt_q;
  rks_lane_ctl_t vctl, cctl;

  logic [IDX_W-1:0] rx;
  logic [IDX_W-1:0] vi0, vi1, vi2, ci0, ci1, ci2, ci3;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign match     = run_open && (data_byte == held_byte) && (run_length != RUN_MAX);
  assign emit_prev = run_open && !match;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == S_DONE) && out_free;

  // Lane load: close the held run, or the final run of the stream
  always_comb begin
    lane_load = 1'b0;
    ld_val    = held_byte;
    ld_cnt    = run_length;
    ld_par    = parity;
    if (in_fire && emit_prev) begin
      lane_load = 1'b1;
    end else if (in_fire && end_of_stream) begin
      lane_load = 1'b1;
      ld_val    = match ? held_byte : data_byte;
      ld_cnt    = match ? run_length + 8'd1 : 8'd1;
    end else if (out_load && !cur_last && pending_end) begin
      lane_load = 1'b1;
      ld_par    = !parity;
    end
  end

  // Round counter and key schedule; keys are computed from the next round index and registered
  always_comb begin
    if (lane_load) begin
      rnd_next = '0;
    end else if (state == S_RUN) begin
      rnd_next = rnd + 1'b1;
    end else begin
      rnd_next = rnd;
    end
  end

  assign rx  = IDX_W'(rnd_next);
  assign vi0 = rx;
  assign vi1 = rx + IDX_W'(1);
  assign vi2 = rx + IDX_W'(2);
  assign ci0 = IDX_W'(KEY_LEN - 1) - rx;
  assign ci1 = IDX_W'(KEY_LEN - 2) - rx;
  assign ci2 = IDX_W'(KEY_LEN - 3) - rx;
  assign ci3 = IDX_W'(KEY_LEN - 4) - rx;

  always_ff @(posedge clk) begin
    rnd <= rnd_next;
    vk1 <= SBOX[vi0[7:0]] ^ SBOX[vi2[7:0]];
    vk2 <= SBOX[vi1[7:0]];
    ck1 <= SBOX[ci1[7:0]] ^ SBOX[ci2[7:0]];
    ck2 <= SBOX[ci0[7:0]] ^ SBOX[ci3[7:0]];
    if (lane_load) begin
      lane_par <= ld_par;
    end
  end

  // Value lane inverts on even parity, count lane on odd
  assign vctl = '{load: lane_load, step: (state == S_RUN), inv: !lane_par};
  assign cctl = '{load: lane_load, step: (state == S_RUN), inv: lane_par};

  rks_round #(.ROT_AMT(ROT)) u_val_lane (
    .clk      (clk),
    .ctl      (vctl),
    .load_val (ld_val),
    .k1       (vk1),
    .k2       (vk2),
    .val      (val_q)
  );

  rks_round #(.ROT_AMT(2 * ROT)) u_cnt_lane (
    .clk      (clk),
    .ctl      (cctl),
    .load_val (ld_cnt),
    .k1       (ck1),
    .k2       (ck2),
    .val      (cnt_q)
  );

  // Sequencer and run tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      held_byte   <= 8'd0;
      run_length  <= 8'd0;
      run_open    <= 1'b0;
      parity      <= 1'b1;
      pending_end <= 1'b0;
      cur_last    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (match) begin
              run_length <= run_length + 8'd1;
            end else begin
              held_byte  <= data_byte;
              run_length <= 8'd1;
              run_open   <= 1'b1;
            end
            if (emit_prev) begin
              cur_last    <= 1'b0;
              pending_end <= end_of_stream;
              state       <= S_RUN;
            end else if (end_of_stream) begin
              cur_last    <= 1'b1;
              pending_end <= 1'b0;
              state       <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (rnd == RND_W'(ROUNDS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (cur_last) begin
              held_byte  <= 8'd0;
              run_length <= 8'd0;
              run_open   <= 1'b0;
              parity     <= 1'b1;
              state      <= S_IDLE;
            end else begin
              parity <= !parity;
              if (pending_end) begin
                cur_last    <= 1'b1;
                pending_end <= 1'b0;
                state       <= S_RUN;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      coded_value <= val_q;
      coded_count <= cnt_q;
      last_pair   <= cur_last;
    end
  end

  // Checks
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) && (rnd == RND_W'(ROUNDS - 1)) |=> (state == S_DONE))
    else $error("round sequence did not finish on its last round");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    out_load && cur_last |=> !run_open && parity && (state == S_IDLE))
    else $error("run state not cleared after final pair");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pending_end)
    else $error("pending final pair left while idle");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("output beat raised outside hand-off");

endmodule
